// ----- design/mue_pkg.sv -----
// mue_pkg: shared types and constants of the unique edge table
// no dependencies
package mue_pkg;

    localparam int VERTEX_BITS = 16;

    typedef struct packed {
        logic [VERTEX_BITS-1:0] vertex_a;
        logic [VERTEX_BITS-1:0] vertex_b;
        logic [VERTEX_BITS-1:0] vertex_c;
        logic                   first_of_object;
    } tri_req_t;

    typedef struct packed {
        logic [VERTEX_BITS-1:0] edge_start;
        logic [VERTEX_BITS-1:0] edge_end;
        logic                   last_of_run;
        logic                   overflow;
    } edge_rsp_t;

    // triangle after index masking, as queued between front and back
    typedef struct packed {
        logic [VERTEX_BITS-1:0] v0;
        logic [VERTEX_BITS-1:0] v1;
        logic [VERTEX_BITS-1:0] v2;
        logic                   clear;
    } tri_t;

    typedef struct packed {
        logic [VERTEX_BITS-1:0] s;
        logic [VERTEX_BITS-1:0] e;
    } edge_t;

    // edge of the triangle under test
    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_NEW,
        ST_FINISH
    } state_t;

    function automatic logic same_edge(edge_t a, edge_t b);
        return ((a.s == b.s) && (a.e == b.e)) || ((a.s == b.e) && (a.e == b.s));
    endfunction

endpackage

// ----- design/mue_ram.sv -----
// mue_ram: generic single write port, single read port ram with registered read
// no dependencies
module mue_ram #(
    parameter int WIDTH     = 32,
    parameter int DEPTH     = 256,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/mue_front.sv -----
// mue_front: input stage, masks vertex indices and forms the triangle record
// depends on mue_pkg
module mue_front #(
    parameter int STORE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tri_valid,
    output logic               tri_ready,
    input  mue_pkg::tri_req_t  tri_data,
    output logic               push_valid,
    input  logic               push_ready,
    output mue_pkg::tri_t      push_data
);
    import mue_pkg::*;

    localparam logic [VERTEX_BITS-1:0] VMASK =
        VERTEX_BITS'((32'd1 << STORE_BITS) - 32'd1);

    logic  vld_reg;
    logic  vld_next;
    tri_t  item_reg;
    tri_t  item_next;

    always_comb
    begin
        tri_ready = !vld_reg || push_ready;
        vld_next  = vld_reg;
        item_next = item_reg;
        if (push_ready)
        begin
            vld_next = 1'b0;
        end
        if (tri_valid && tri_ready)
        begin
            vld_next        = 1'b1;
            item_next.v0    = tri_data.vertex_a & VMASK;
            item_next.v1    = tri_data.vertex_b & VMASK;
            item_next.v2    = tri_data.vertex_c & VMASK;
            item_next.clear = tri_data.first_of_object;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign push_valid = vld_reg;
    assign push_data  = item_reg;

endmodule

// ----- design/mue_queue.sv -----
// mue_queue: two-entry queue of triangle records between front and back
// depends on mue_pkg
module mue_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  mue_pkg::tri_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output mue_pkg::tri_t pop_data
);
    import mue_pkg::*;

    localparam int DEPTH = 2;

    tri_t       slot_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        push_ready  = cnt_reg != 2'(DEPTH);
        pop_valid   = cnt_reg != 2'd0;
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];

endmodule

// ----- design/mue_back.sv -----
// mue_back: sequencer that scans the edge table per edge and emits new edges
// depends on mue_pkg and mue_ram
module mue_back #(
    parameter int MAX_EDGES  = 256,
    parameter int STORE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  mue_pkg::tri_t      pop_data,
    output logic               edge_valid,
    input  logic               edge_ready,
    output mue_pkg::edge_rsp_t edge_data
);
    import mue_pkg::*;

    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int EW = 2 * STORE_BITS;
    localparam logic [CW-1:0] FULL = CW'(MAX_EDGES);

    state_t     state_reg;
    state_t     state_next;
    tri_t       tri_reg;
    tri_t       tri_next;
    logic [1:0] k_reg;
    logic [1:0] k_next;
    logic [1:0] nloc_reg;
    logic [1:0] nloc_next;
    edge_t      loc0_reg;
    edge_t      loc0_next;
    edge_t      loc1_reg;
    edge_t      loc1_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] rd_idx_reg;
    logic [CW-1:0] rd_idx_next;
    logic       cmp_vld_reg;
    logic       cmp_vld_next;
    logic       pend_vld_reg;
    logic       pend_vld_next;
    edge_rsp_t  pend_reg;
    edge_rsp_t  pend_next;
    logic       out_vld_reg;
    logic       out_vld_next;
    edge_rsp_t  out_reg;
    edge_rsp_t  out_next;

    edge_t         cur;
    logic          loc_hit;
    logic          ram_hit;
    logic          out_free;
    logic          rd_en;
    logic          wr_en;
    logic [EW-1:0] rd_data;
    logic [EW-1:0] wr_data;
    logic [STORE_BITS-1:0] st_s;
    logic [STORE_BITS-1:0] st_e;

    mue_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EDGES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        case (k_reg)
            EDGE_AB: cur = '{s: tri_reg.v0, e: tri_reg.v1};
            EDGE_BC: cur = '{s: tri_reg.v1, e: tri_reg.v2};
            default: cur = '{s: tri_reg.v2, e: tri_reg.v0};
        endcase

        st_s     = rd_data[EW-1:STORE_BITS];
        st_e     = rd_data[STORE_BITS-1:0];
        loc_hit  = ((nloc_reg != 2'd0) && same_edge(loc0_reg, cur))
                || ((nloc_reg == 2'd2) && same_edge(loc1_reg, cur));
        ram_hit  = cmp_vld_reg
                && (((st_s == cur.s[STORE_BITS-1:0]) && (st_e == cur.e[STORE_BITS-1:0]))
                ||  ((st_s == cur.e[STORE_BITS-1:0]) && (st_e == cur.s[STORE_BITS-1:0])));
        out_free = !out_vld_reg || edge_ready;
        wr_data  = {cur.s[STORE_BITS-1:0], cur.e[STORE_BITS-1:0]};

        state_next    = state_reg;
        tri_next      = tri_reg;
        k_next        = k_reg;
        nloc_next     = nloc_reg;
        loc0_next     = loc0_reg;
        loc1_next     = loc1_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_vld_next  = 1'b0;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg && !edge_ready;
        pop_ready     = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    tri_next   = pop_data;
                    k_next     = EDGE_AB;
                    nloc_next  = 2'd0;
                    state_next = ST_CHECK;
                    if (pop_data.clear)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_CHECK:
            begin
                rd_idx_next = '0;
                state_next  = ST_SCAN;
                if (loc_hit)
                begin
                    state_next = (k_reg == EDGE_CA) ? ST_FINISH : ST_CHECK;
                    k_next     = k_reg + 2'd1;
                end
            end
            ST_SCAN:
            begin
                if (ram_hit)
                begin
                    state_next = (k_reg == EDGE_CA) ? ST_FINISH : ST_CHECK;
                    k_next     = k_reg + 2'd1;
                end
                else if (rd_idx_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
                else
                begin
                    state_next = ST_NEW;
                end
            end
            ST_NEW:
            begin
                if (!pend_vld_reg || out_free)
                begin
                    if (pend_vld_reg)
                    begin
                        out_vld_next = 1'b1;
                        out_next     = pend_reg;
                    end
                    pend_vld_next = 1'b1;
                    pend_next     = '{edge_start: cur.s, edge_end: cur.e,
                                      last_of_run: 1'b0, overflow: count_reg == FULL};
                    if (count_reg != FULL)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (nloc_reg == 2'd0)
                    begin
                        loc0_next = cur;
                    end
                    else
                    begin
                        loc1_next = cur;
                    end
                    nloc_next  = nloc_reg + 2'd1;
                    state_next = (k_reg == EDGE_CA) ? ST_FINISH : ST_CHECK;
                    k_next     = k_reg + 2'd1;
                end
            end
            ST_FINISH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_vld_next         = 1'b1;
                    out_next             = pend_reg;
                    out_next.last_of_run = 1'b1;
                    pend_vld_next        = 1'b0;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            k_reg        <= EDGE_AB;
            nloc_reg     <= 2'd0;
            count_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            nloc_reg     <= nloc_next;
            count_reg    <= count_next;
            cmp_vld_reg  <= cmp_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tri_reg    <= tri_next;
        loc0_reg   <= loc0_next;
        loc1_reg   <= loc1_next;
        rd_idx_reg <= rd_idx_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    assign edge_valid = out_vld_reg;
    assign edge_data  = out_reg;

endmodule

// ----- design/mesh_unique_edge_table_top.sv -----
// mesh_unique_edge_table_top: unique edge extraction for triangle meshes
// depends on mue_pkg, mue_front, mue_queue, mue_back
//
// Each request on the tri channel is one triangle; its edges a-b, b-c, c-a are looked
// up in an edge table held in one ram with a single read port, scanned one entry per
// cycle, and every edge not found there or earlier in the same triangle comes out on
// the edge channel, last_of_run marking the final one of the triangle. While the back
// end works through a triangle, the front stage and a two-entry queue take further
// triangles. first_of_object empties the table. When the table is full, new edges still
// come out but with overflow set, unstored.
module mesh_unique_edge_table_top #(
    parameter int MAX_EDGES  = 256,
    parameter int INDEX_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tri_valid,
    output logic               tri_ready,
    input  mue_pkg::tri_req_t  tri_data,
    output logic               edge_valid,
    input  logic               edge_ready,
    output mue_pkg::edge_rsp_t edge_data
);
    import mue_pkg::*;

    localparam int STORE_BITS = (INDEX_BITS < VERTEX_BITS) ? INDEX_BITS : VERTEX_BITS;

    logic push_valid;
    logic push_ready;
    tri_t push_data;
    logic pop_valid;
    logic pop_ready;
    tri_t pop_data;

    mue_front #(
        .STORE_BITS (STORE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tri_valid  (tri_valid),
        .tri_ready  (tri_ready),
        .tri_data   (tri_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mue_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mue_back #(
        .MAX_EDGES  (MAX_EDGES),
        .STORE_BITS (STORE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .edge_valid (edge_valid),
        .edge_ready (edge_ready),
        .edge_data  (edge_data)
    );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for mesh_unique_edge_table_top, unique edge extraction
// depends on mue_pkg and the design; predicts every new edge and checks each one in order
module testbench;
    import mue_pkg::*;

    localparam int MAX_EDGES    = 256;
    localparam int INDEX_BITS   = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 1000;
    localparam logic [VERTEX_BITS-1:0] INDEX_MASK = VERTEX_BITS'((64'd1 << INDEX_BITS) - 1);

    logic      clk;
    logic      rst_n;
    logic      tri_valid;
    logic      tri_ready;
    tri_req_t  tri_data;
    logic      edge_valid;
    logic      edge_ready;
    edge_rsp_t edge_data;

    edge_t     known_edges [MAX_EDGES];
    int        known_count;
    edge_rsp_t pending_edges [$];
    edge_rsp_t oldest_edge;
    int        error_count;
    int        cycle_count;
    int        hold_cycles;
    bit        no_idle;

    mesh_unique_edge_table_top #(
        .MAX_EDGES (MAX_EDGES),
        .INDEX_BITS(INDEX_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_valid (tri_valid),
        .tri_ready (tri_ready),
        .tri_data  (tri_data),
        .edge_valid(edge_valid),
        .edge_ready(edge_ready),
        .edge_data (edge_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit undirected_equal(input edge_t x, input edge_t y);
        return ({x.s, x.e} == {y.s, y.e}) || ({x.s, x.e} == {y.e, y.s});
    endfunction

    function automatic void predict_new_edges(input tri_req_t t);
        logic [VERTEX_BITS-1:0] v [3];
        edge_t                  seen [3];
        int                     n_seen;
        edge_rsp_t              found [$];
        edge_rsp_t              r;
        edge_t                  cand;
        bit                     hit;
        v[0] = t.vertex_a & INDEX_MASK;
        v[1] = t.vertex_b & INDEX_MASK;
        v[2] = t.vertex_c & INDEX_MASK;
        n_seen = 0;
        if (t.first_of_object)
            known_count = 0;
        for (int k = 0; k < 3; k++)
        begin
            cand.s = v[k];
            cand.e = v[(k + 1) % 3];
            hit = 1'b0;
            for (int i = 0; i < known_count; i++)
                if (undirected_equal(known_edges[i], cand))
                    hit = 1'b1;
            for (int j = 0; j < n_seen; j++)
                if (undirected_equal(seen[j], cand))
                    hit = 1'b1;
            if (!hit)
            begin
                seen[n_seen] = cand;
                n_seen++;
                r.edge_start  = cand.s;
                r.edge_end    = cand.e;
                r.last_of_run = 1'b0;
                r.overflow    = (known_count >= MAX_EDGES);
                if (!r.overflow)
                begin
                    known_edges[known_count] = cand;
                    known_count++;
                end
                found.push_back(r);
            end
        end
        if (found.size() > 0)
        begin
            r = found.pop_back();
            r.last_of_run = 1'b1;
            found.push_back(r);
        end
        foreach (found[i])
            pending_edges.push_back(found[i]);
    endfunction

    task automatic record_error(input string what, input edge_rsp_t want, input edge_rsp_t got);
        error_count++;
        if (error_count <= 10)
            $display("%s: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                     what, want.edge_start, want.edge_end, want.last_of_run, want.overflow,
                     got.edge_start, got.edge_end, got.last_of_run, got.overflow);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && edge_valid && edge_ready)
        begin
            if (pending_edges.size() == 0)
                record_error("unexpected edge", '0, edge_data);
            else
            begin
                oldest_edge = pending_edges.pop_front();
                if (edge_data.edge_start !== oldest_edge.edge_start
                    || edge_data.edge_end !== oldest_edge.edge_end
                    || edge_data.last_of_run !== oldest_edge.last_of_run
                    || edge_data.overflow !== oldest_edge.overflow)
                    record_error("edge mismatch", oldest_edge, edge_data);
            end
        end
    end

    initial
    begin : edge_sink
        int pause;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                edge_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            pause = no_idle ? 0 : $urandom_range(0, 19);
            if (pause > 0)
            begin
                edge_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            edge_ready <= 1'b1;
            do
                @(posedge clk);
            while (!edge_valid);
        end
    end

    task automatic send_tri(input logic [VERTEX_BITS-1:0] a, input logic [VERTEX_BITS-1:0] b,
                            input logic [VERTEX_BITS-1:0] c, input logic first);
        tri_req_t req;
        int       gap;
        req.vertex_a        = a;
        req.vertex_b        = b;
        req.vertex_c        = c;
        req.first_of_object = first;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            tri_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tri_data  <= req;
        tri_valid <= 1'b1;
        do
            @(posedge clk);
        while (!tri_ready);
        predict_new_edges(req);
    endtask

    task automatic test_corner_triangles();
        send_tri(16'd0, 16'd0, 16'd0, 1'b1);
        send_tri(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_tri(16'd1, 16'd2, 16'd3, 1'b1);
        send_tri(16'd3, 16'd2, 16'd1, 1'b0);
        send_tri(16'd1, 16'd2, 16'd4, 1'b0);
        send_tri(16'hFFFF, 16'd0, 16'h8000, 1'b0);
        send_tri(16'hAAAA, 16'h5555, 16'hFFFF, 1'b0);
        send_tri(16'd5, 16'd5, 16'd6, 1'b0);
        send_tri(16'd6, 16'd5, 16'd5, 1'b0);
        send_tri(16'd1, 16'd2, 16'd3, 1'b1);
        send_tri(16'd2, 16'd3, 16'd1, 1'b0);
        send_tri(16'h5555, 16'hAAAA, 16'h0001, 1'b0);
    endtask

    task automatic test_table_overflow();
        logic [VERTEX_BITS-1:0] base;
        base = VERTEX_BITS'($urandom_range(0, 65535 - 400));
        for (int k = 0; k < 86; k++)
            send_tri(base + VERTEX_BITS'(3 * k), base + VERTEX_BITS'(3 * k + 1),
                     base + VERTEX_BITS'(3 * k + 2), k == 0);
        // full table: repeat within the triangle still suppressed
        send_tri(base + 16'd300, base + 16'd301, base + 16'd300, 1'b0);
        send_tri(base, base + 16'd1, base + 16'd2, 1'b0);
        send_tri(base + 16'd2, base + 16'd1, base, 1'b0);
        send_tri(base + 16'd1, base, base + 16'd5, 1'b1);
    endtask

    task automatic test_output_backpressure();
        no_idle = 1'b1;
        hold_cycles = 3000;
        send_tri(16'd100, 16'd200, 16'd300, 1'b1);
        for (int k = 0; k < 12; k++)
            send_tri(VERTEX_BITS'($urandom), VERTEX_BITS'($urandom),
                     VERTEX_BITS'($urandom), 1'($urandom_range(0, 1)));
        no_idle = 1'b0;
    endtask

    task automatic test_random_meshes();
        logic [VERTEX_BITS-1:0] pool [24];
        int                     sent;
        int                     pool_size;
        int                     n_tris;
        logic [VERTEX_BITS-1:0] base;
        sent = 0;
        while (sent < 8)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                send_tri(VERTEX_BITS'($urandom), VERTEX_BITS'($urandom),
                         VERTEX_BITS'($urandom), 1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                pool_size = $urandom_range(3, 24);
                n_tris    = $urandom_range(3, 8);
                base      = VERTEX_BITS'($urandom);
                foreach (pool[i])
                    pool[i] = ($urandom_range(0, 3) == 0) ? VERTEX_BITS'($urandom)
                                                          : base + VERTEX_BITS'(i);
                for (int k = 0; k < n_tris; k++)
                begin
                    send_tri(pool[$urandom_range(0, pool_size - 1)],
                             pool[$urandom_range(0, pool_size - 1)],
                             pool[$urandom_range(0, pool_size - 1)], k == 0);
                    sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        tri_valid   <= 1'b0;
        tri_data    <= '0;
        edge_ready  <= 1'b0;
        known_count = 0;
        error_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        no_idle     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_triangles();
        test_table_overflow();
        test_output_backpressure();
        test_random_meshes();

        tri_valid <= 1'b0;
        while (pending_edges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/mue_pkg.sv
design/mue_ram.sv
design/mue_front.sv
design/mue_queue.sv
design/mue_back.sv
design/mesh_unique_edge_table_top.sv
dv/testbench.sv
